/* hw/rtl/cau_pkg.sv */
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_CONJ  = 3'd4,
		CMD_NEG   = 3'd5,
		CMD_RECIP = 3'd6,
		CMD_SCALE = 3'd7
	} cmd_t;

	// Datapath class chosen by the front end.
	typedef enum logic [1:0] {
		KIND_LIN = 2'd0,
		KIND_MUL = 2'd1,
		KIND_DIV = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  sub_re;
		logic  sub_im;
	} ctrl_t;

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

endpackage
`default_nettype wire

/* hw/rtl/cau_front.sv */
// Front end: decodes the command and maps operands onto the shared datapath.
`default_nettype none
module cau_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  wire logic [cau_pkg::CMD_W-1:0] command,
	input  wire logic signed [W-1:0]       a_re,
	input  wire logic signed [W-1:0]       a_im,
	input  wire logic signed [W-1:0]       b_re,
	input  wire logic signed [W-1:0]       b_im,
	output cau_pkg::ctrl_t                 ctrl,
	output logic signed [W-1:0]            u_re,
	output logic signed [W-1:0]            u_im,
	output logic signed [W-1:0]            v_re,
	output logic signed [W-1:0]            v_im
);

	localparam logic [W-1:0] ONE = W'(1) << F;

	always_comb begin
		ctrl.kind   = cau_pkg::KIND_LIN;
		ctrl.sub_re = 1'b0;
		ctrl.sub_im = 1'b0;
		u_re = a_re;
		u_im = a_im;
		v_re = b_re;
		v_im = b_im;
		unique case (cau_pkg::cmd_t'(command))
			cau_pkg::CMD_ADD: begin
			end
			cau_pkg::CMD_SUB: begin
				ctrl.sub_re = 1'b1;
				ctrl.sub_im = 1'b1;
			end
			cau_pkg::CMD_MUL: begin
				ctrl.kind = cau_pkg::KIND_MUL;
			end
			cau_pkg::CMD_DIV: begin
				ctrl.kind = cau_pkg::KIND_DIV;
			end
			cau_pkg::CMD_CONJ: begin
				u_im = '0;
				v_re = '0;
				v_im = a_im;
				ctrl.sub_im = 1'b1;
			end
			cau_pkg::CMD_NEG: begin
				u_re = '0;
				u_im = '0;
				v_re = a_re;
				v_im = a_im;
				ctrl.sub_re = 1'b1;
				ctrl.sub_im = 1'b1;
			end
			cau_pkg::CMD_RECIP: begin
				// 1 / a: numerator is (1.0, 0)
				ctrl.kind = cau_pkg::KIND_DIV;
				u_re = ONE;
				u_im = '0;
				v_re = a_re;
				v_im = a_im;
			end
			cau_pkg::CMD_SCALE: begin
				// real scale is a product with b_im forced to zero
				ctrl.kind = cau_pkg::KIND_MUL;
				v_im = '0;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/cau_fifo.sv */
// Short queue between front end and back end.
`default_nettype none
module cau_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = cau_pkg::FIFO_AW;

	logic [WIDTH-1:0] mem_q [cau_pkg::FIFO_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;

	assign full    = (cnt_q == (AW+1)'(cau_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + AW'(1);
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* hw/rtl/cau_back.sv */
// Back end: product, rounding, pipelined divider and saturation.
`default_nettype none
module cau_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire cau_pkg::ctrl_t      in_ctrl,
	input  wire logic signed [W-1:0] u_re,
	input  wire logic signed [W-1:0] u_im,
	input  wire logic signed [W-1:0] v_re,
	input  wire logic signed [W-1:0] v_im,
	output logic                     in_take,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [W-1:0]             res_re,
	output logic [W-1:0]             res_im,
	output logic                     res_dz,
	output logic                     res_ovf
);

	localparam int PW = 2 * W;
	localparam int XW = PW + W + F + 2;
	localparam int SW = 2 * W + 7;
	localparam logic [PW:0]  HALF = ((PW+1)'(1) << F) >> 1;
	localparam logic [PW:0]  LIM  = (PW+1)'(1) << (W - 1);
	localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

	// saturate a sign/magnitude value into W bits, lsb of result is ovf
	function automatic logic [W:0] sat_mag(input logic neg, input logic [PW:0] mag);
		logic ovf;
		logic [W-1:0] val;
		ovf = neg ? (mag > LIM) : (mag >= LIM);
		if (ovf) val = neg ? MINN : MAXP;
		else     val = neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0];
		return {val, ovf};
	endfunction

	function automatic logic [W:0] sat_lin(input logic signed [W:0] x);
		logic ovf;
		logic [W-1:0] val;
		ovf = x[W] ^ x[W-1];
		val = ovf ? (x[W] ? MINN : MAXP) : x[W-1:0];
		return {val, ovf};
	endfunction

	logic en;
	assign en      = !out_valid || out_ready;
	assign in_take = en && in_valid;

	// stage 1: products and add/sub path
	logic                 v_s1;
	logic signed [PW-1:0] p1_s1, p2_s1, p3_s1, p4_s1, d1_s1, d2_s1;
	cau_pkg::kind_t       kind_s1;
	logic [W-1:0]         lin_re_s1, lin_im_s1;
	logic                 lin_ovf_s1;
	logic signed [W:0]    lre_c, lim_c;
	logic [W:0]           lsre_c, lsim_c;

	always_comb begin
		lre_c  = in_ctrl.sub_re ? ((W+1)'(u_re) - (W+1)'(v_re)) : ((W+1)'(u_re) + (W+1)'(v_re));
		lim_c  = in_ctrl.sub_im ? ((W+1)'(u_im) - (W+1)'(v_im)) : ((W+1)'(u_im) + (W+1)'(v_im));
		lsre_c = sat_lin(lre_c);
		lsim_c = sat_lin(lim_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1      <= PW'(u_re) * PW'(v_re);
			p2_s1      <= PW'(u_im) * PW'(v_im);
			p3_s1      <= PW'(u_re) * PW'(v_im);
			p4_s1      <= PW'(u_im) * PW'(v_re);
			d1_s1      <= PW'(v_re) * PW'(v_re);
			d2_s1      <= PW'(v_im) * PW'(v_im);
			kind_s1    <= in_ctrl.kind;
			lin_re_s1  <= lsre_c[W:1];
			lin_im_s1  <= lsim_c[W:1];
			lin_ovf_s1 <= lsre_c[0] | lsim_c[0];
		end
	end

	// stage 2: sums and squared magnitude
	logic               v_s2;
	logic signed [PW:0] num_re_s2, num_im_s2;
	logic [PW-1:0]      den_s2;
	cau_pkg::kind_t     kind_s2;
	logic [W-1:0]       lin_re_s2, lin_im_s2;
	logic               lin_ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (kind_s1 == cau_pkg::KIND_MUL) begin
				num_re_s2 <= (PW+1)'(p1_s1) - (PW+1)'(p2_s1);
				num_im_s2 <= (PW+1)'(p3_s1) + (PW+1)'(p4_s1);
			end else begin
				num_re_s2 <= (PW+1)'(p1_s1) + (PW+1)'(p2_s1);
				num_im_s2 <= (PW+1)'(p4_s1) - (PW+1)'(p3_s1);
			end
			den_s2     <= d1_s1 + d2_s1;
			kind_s2    <= kind_s1;
			lin_re_s2  <= lin_re_s1;
			lin_im_s2  <= lin_im_s1;
			lin_ovf_s2 <= lin_ovf_s1;
		end
	end

	// stage 3: sign and magnitude
	logic           v_s3;
	logic           neg_re_s3, neg_im_s3, dz_s3;
	logic [PW:0]    mag_re_s3, mag_im_s3;
	logic [PW-1:0]  den_s3;
	cau_pkg::kind_t kind_s3;
	logic [W-1:0]   lin_re_s3, lin_im_s3;
	logic           lin_ovf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_re_s3  <= num_re_s2[PW];
			neg_im_s3  <= num_im_s2[PW];
			mag_re_s3  <= num_re_s2[PW] ? ((PW+1)'(0) - num_re_s2) : num_re_s2;
			mag_im_s3  <= num_im_s2[PW] ? ((PW+1)'(0) - num_im_s2) : num_im_s2;
			den_s3     <= den_s2;
			dz_s3      <= (kind_s2 == cau_pkg::KIND_DIV) && (den_s2 == '0);
			kind_s3    <= kind_s2;
			lin_re_s3  <= lin_re_s2;
			lin_im_s3  <= lin_im_s2;
			lin_ovf_s3 <= lin_ovf_s2;
		end
	end

	// stage 4: product rounding, divider setup and range check
	logic [PW:0]  rm_re_c, rm_im_c;
	logic [W:0]   ms_re_c, ms_im_c;
	logic [W-1:0] fr_re_c, fr_im_c;
	logic         fovf_c;
	logic [XW-1:0] ns_re_c, ns_im_c, dsh_c;

	always_comb begin
		rm_re_c = (mag_re_s3 + HALF) >> F;
		rm_im_c = (mag_im_s3 + HALF) >> F;
		ms_re_c = sat_mag(neg_re_s3, rm_re_c);
		ms_im_c = sat_mag(neg_im_s3, rm_im_c);
		if (kind_s3 == cau_pkg::KIND_MUL) begin
			fr_re_c = ms_re_c[W:1];
			fr_im_c = ms_im_c[W:1];
			fovf_c  = ms_re_c[0] | ms_im_c[0];
		end else begin
			fr_re_c = lin_re_s3;
			fr_im_c = lin_im_s3;
			fovf_c  = lin_ovf_s3;
		end
		ns_re_c = XW'(mag_re_s3) << (F + 1);
		ns_im_c = XW'(mag_im_s3) << (F + 1);
		dsh_c   = XW'(den_s3) << (W + 1);
	end

	// divider stages: index 0 is loaded here, index W+1 leaves the divider
	logic          vld_sd  [W+2];
	logic [SW-1:0] side_sd [W+2];
	logic [XW-1:0] den_sd  [W+2];
	logic [XW-1:0] rre_sd  [W+2];
	logic [XW-1:0] rim_sd  [W+2];
	logic [W:0]    qre_sd  [W+2];
	logic [W:0]    qim_sd  [W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd[0] <= 1'b0;
		else if (en) vld_sd[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= {fovf_c, ns_im_c >= dsh_c, ns_re_c >= dsh_c, neg_im_s3, neg_re_s3,
				dz_s3, kind_s3 == cau_pkg::KIND_DIV, fr_im_c, fr_re_c};
			den_sd[0]  <= XW'(den_s3);
			rre_sd[0]  <= ns_re_c;
			rim_sd[0]  <= ns_im_c;
			qre_sd[0]  <= '0;
			qim_sd[0]  <= '0;
		end
	end

	for (genvar j = 0; j <= W; j++) begin : g_div
		logic [XW-1:0] dk;
		logic          ge_re, ge_im;
		assign dk    = den_sd[j] << (W - j);
		assign ge_re = rre_sd[j] >= dk;
		assign ge_im = rim_sd[j] >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[j+1] <= 1'b0;
			else if (en) vld_sd[j+1] <= vld_sd[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sd[j+1] <= side_sd[j];
				den_sd[j+1]  <= den_sd[j];
				rre_sd[j+1]  <= ge_re ? (rre_sd[j] - dk) : rre_sd[j];
				rim_sd[j+1]  <= ge_im ? (rim_sd[j] - dk) : rim_sd[j];
				qre_sd[j+1]  <= {qre_sd[j][W-1:0], ge_re};
				qim_sd[j+1]  <= {qim_sd[j][W-1:0], ge_im};
			end
		end
	end

	// output stage: quotient rounding and result select
	logic [SW-1:0] sd_c;
	logic [W+1:0]  qr_re_c, qr_im_c;
	logic [W:0]    qs_re_c, qs_im_c;

	always_comb begin
		sd_c    = side_sd[W+1];
		qr_re_c = ({1'b0, qre_sd[W+1]} + (W+2)'(1)) >> 1;
		qr_im_c = ({1'b0, qim_sd[W+1]} + (W+2)'(1)) >> 1;
		qs_re_c = sat_mag(sd_c[2*W+2], (PW+1)'(qr_re_c));
		qs_im_c = sat_mag(sd_c[2*W+3], (PW+1)'(qr_im_c));
		if (sd_c[2*W+4]) qs_re_c = {sd_c[2*W+2] ? MINN : MAXP, 1'b1};
		if (sd_c[2*W+5]) qs_im_c = {sd_c[2*W+3] ? MINN : MAXP, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_sd[W+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_c[2*W+1]) begin
				res_re  <= '0;
				res_im  <= '0;
				res_dz  <= 1'b1;
				res_ovf <= 1'b0;
			end else if (sd_c[2*W]) begin
				res_re  <= qs_re_c[W:1];
				res_im  <= qs_im_c[W:1];
				res_dz  <= 1'b0;
				res_ovf <= qs_re_c[0] | qs_im_c[0];
			end else begin
				res_re  <= sd_c[W-1:0];
				res_im  <= sd_c[2*W-1:W];
				res_dz  <= 1'b0;
				res_ovf <= sd_c[2*W+6];
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit.
// Complex arithmetic unit, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
// Input stream s_*: s_tuser carries the command (add, sub, mul, div, conjugate,
//   negate, reciprocal, real scale); s_tdata carries a_re, a_im, b_re, b_im.
// Output stream m_*: m_tdata carries res_re, res_im; m_tuser flags divide by
//   zero and saturation.
// A front end decodes each item into a common operand form and pushes it into
//   a four-entry queue; the back end is a fixed pipeline (products, sums,
//   magnitudes, rounding, then a one-bit-per-stage divider of DATA_WIDTH+1
//   stages, then an output register).
// Ordering: every command takes the same path through the pipeline, so results
//   keep input order.
// Throughput: one item per cycle unless stalled; the divider stages set the depth, not the rate.
// Stall: while m_tvalid is high and m_tready low the whole back pipeline holds;
//   the queue absorbs up to four more items, then s_tready drops.
// Reset: arst_n clears the queue and all valid bits; no item is in flight after.
// Products and quotients round to nearest, ties away from zero; every result
//   part saturates to the signed range and raises overflow. Division by zero
//   returns zero with div_by_zero set.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
	input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
	// command
	input  wire logic [cau_pkg::CMD_W-1:0]             s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// res_re, res_im from the lowest bit up, zero padded to bytes
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]          m_tdata,
	// div_by_zero, overflow
	output logic [1:0]                                 m_tuser
);

	localparam int W   = DATA_WIDTH;
	localparam int ODW = ((2*DATA_WIDTH+7)/8)*8;
	localparam int EW  = $bits(cau_pkg::ctrl_t) + 4 * W;

	cau_pkg::ctrl_t   f_ctrl, b_ctrl;
	logic signed [W-1:0] f_ure, f_uim, f_vre, f_vim;
	logic signed [W-1:0] b_ure, b_uim, b_vre, b_vim;
	logic [EW-1:0]    q_rd;
	logic             q_full, q_empty, take;
	logic [W-1:0]     res_re, res_im;
	logic             res_dz, res_ovf;

	cau_front #(.W(W), .F(FRAC_BITS)) u_front (
		.command (s_tuser),
		.a_re    (s_tdata[W-1:0]),
		.a_im    (s_tdata[2*W-1:W]),
		.b_re    (s_tdata[3*W-1:2*W]),
		.b_im    (s_tdata[4*W-1:3*W]),
		.ctrl    (f_ctrl),
		.u_re    (f_ure),
		.u_im    (f_uim),
		.v_re    (f_vre),
		.v_im    (f_vim)
	);

	assign s_tready = !q_full;

	cau_fifo #(.WIDTH(EW)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s_tvalid && s_tready),
		.wr_data ({f_ctrl, f_vim, f_vre, f_uim, f_ure}),
		.rd_en   (take),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {b_ctrl, b_vim, b_vre, b_uim, b_ure} = q_rd;

	cau_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.in_ctrl   (b_ctrl),
		.u_re      (b_ure),
		.u_im      (b_uim),
		.v_re      (b_vre),
		.v_im      (b_vim),
		.in_take   (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_re    (res_re),
		.res_im    (res_im),
		.res_dz    (res_dz),
		.res_ovf   (res_ovf)
	);

	assign m_tdata = ODW'({res_im, res_re});
	assign m_tuser = {res_ovf, res_dz};

endmodule
`default_nettype wire

/* dv/complex_arithmetic_unit_checker.sv */
// Result checker for the complex arithmetic unit: predicts each result and compares it.
`default_nettype none
module complex_arithmetic_unit_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [127:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [63:0]  m_tdata,
	input  wire logic [1:0]   m_tuser,
	output int                errors,
	output int                pending
);
	import cau_pkg::*;

	typedef logic signed [159:0] big_t;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        dz;
		logic        ovf;
	} cplx_res_t;

	cplx_res_t results_due[$];

	// round to nearest, ties away from zero, dropping 16 fraction bits
	function automatic big_t round_q(input big_t v);
		logic [159:0] mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (160'd1 << 15)) >> 16;
		return v < 0 ? -big_t'(mag) : big_t'(mag);
	endfunction

	// n / den with 16 fraction bits, rounded the same way
	function automatic big_t quot_q(input big_t n, input logic [159:0] den);
		logic [159:0] mag;
		logic [159:0] q;
		mag = n < 0 ? -n : n;
		q = (mag << 17) / den;
		q = (q + 160'd1) >> 1;
		return n < 0 ? -big_t'(q) : big_t'(q);
	endfunction

	function automatic logic [31:0] clamp(input big_t v, inout logic ovf);
		big_t hi;
		big_t lo;
		hi = (big_t'(1) <<< 31) - 1;
		lo = -(big_t'(1) <<< 31);
		if (v > hi) begin
			ovf = 1'b1;
			return hi[31:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	function automatic cplx_res_t predict_result(input cmd_t cmd, input logic [127:0] d);
		big_t ar, ai, br, bi, re, im, xr, xi, yr, yi;
		logic [159:0] den;
		cplx_res_t r;
		ar = big_t'($signed(d[31:0]));
		ai = big_t'($signed(d[63:32]));
		br = big_t'($signed(d[95:64]));
		bi = big_t'($signed(d[127:96]));
		r.dz = 1'b0;
		r.ovf = 1'b0;
		re = ar;
		im = ai;
		xr = ar; xi = ai; yr = br; yi = bi;
		case (cmd)
			CMD_ADD: begin re = ar + br; im = ai + bi; end
			CMD_SUB: begin re = ar - br; im = ai - bi; end
			CMD_MUL: begin
				re = round_q(ar * br - ai * bi);
				im = round_q(ar * bi + ai * br);
			end
			CMD_CONJ: im = -ai;
			CMD_NEG: begin re = -ar; im = -ai; end
			CMD_SCALE: begin re = round_q(ar * br); im = round_q(ai * br); end
			default: begin
				// divide and reciprocal share the conjugate-over-magnitude path
				if (cmd == CMD_RECIP) begin
					xr = big_t'(1) <<< 16; xi = 0; yr = ar; yi = ai;
				end
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					re = quot_q(xr * yr + xi * yi, den);
					im = quot_q(xi * yr - xr * yi, den);
				end
			end
		endcase
		if (r.dz) begin
			r.re = '0;
			r.im = '0;
		end else begin
			r.re = clamp(re, r.ovf);
			r.im = clamp(im, r.ovf);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cplx_res_t e;
		if (arst_n && s_tvalid && s_tready)
			results_due = {results_due, predict_result(cmd_t'(s_tuser), s_tdata)};
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
			end else begin
				e = results_due.pop_front();
				if (m_tdata[31:0] !== e.re || m_tdata[63:32] !== e.im ||
						m_tuser[0] !== e.dz || m_tuser[1] !== e.ovf) begin
					errors <= errors + 1;
					$display("%0t: mismatch expected re=%h im=%h dz=%b ovf=%b, got re=%h im=%h dz=%b ovf=%b",
						$time, e.re, e.im, e.dz, e.ovf,
						m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
				end
			end
		end
		pending <= results_due.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end

endmodule
`default_nettype wire

/* dv/complex_arithmetic_unit_tb.sv */
// Testbench top for the complex arithmetic unit: stimulus, stalls and verdict.
`default_nettype none
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;
	bit           steady = 1'b0;

	complex_arithmetic_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	complex_arithmetic_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send(input cmd_t cmd, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {bi, br, ai, ar};
		do @(posedge clk); while (!s_tready);
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mix of full range, small magnitudes, extremes and zero
	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return MAXV;
			2: return MINV;
			3: return ONE;
			4, 5: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom;
		endcase
	endfunction

	// receiver: random stalls, with calm stretches
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				hold = steady ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] b_re, b_im;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: extremes, every command, zero divisors, saturation
		send(CMD_ADD, MAXV, MINV, MAXV, MINV);
		send(CMD_ADD, 32'h1234_5678, 32'hedcb_a988, 32'h0000_0001, 32'hffff_ffff);
		send(CMD_SUB, MINV, MAXV, MAXV, MINV);
		send(CMD_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
		send(CMD_MUL, MINV, MINV, MINV, MINV);
		send(CMD_MUL, MAXV, MAXV, MAXV, MINV);
		send(CMD_MUL, 32'h0000_8000, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000);
		send(CMD_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0);
		send(CMD_MUL, ONE, ONE, ONE, 32'hffff_0000);
		send(CMD_DIV, ONE, ONE, 32'h0, 32'h0);
		send(CMD_DIV, MAXV, MINV, 32'h0000_0001, 32'h0);
		send(CMD_DIV, ONE, 32'h0, 32'h0003_0000, 32'h0);
		send(CMD_DIV, MINV, MAXV, MINV, MINV);
		send(CMD_DIV, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'hffff_0000);
		send(CMD_CONJ, MINV, MINV, MAXV, MAXV);
		send(CMD_CONJ, MAXV, MAXV, 32'h0, 32'h0);
		send(CMD_NEG, MINV, MAXV, 32'h0, 32'h0);
		send(CMD_NEG, 32'h0, MINV, MINV, MINV);
		send(CMD_RECIP, 32'h0, 32'h0, ONE, ONE);
		send(CMD_RECIP, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
		send(CMD_RECIP, MINV, MAXV, 32'h0, 32'h0);
		send(CMD_RECIP, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
		send(CMD_SCALE, MAXV, MINV, MINV, MAXV);
		send(CMD_SCALE, 32'h0000_0003, 32'hffff_fffd, 32'h0000_8000, 32'h0);
		send(CMD_SCALE, ONE, 32'hffff_0000, 32'hfffe_8000, 32'hdead_beef);

		// random items; a calm stretch, and one drain pause in the middle
		for (int n = 0; n < 800; n++) begin
			if (n == 300) steady = 1'b1;
			if (n == 400) begin
				steady = 1'b0;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			b_re = pick_val();
			b_im = pick_val();
			if ($urandom_range(0, 15) == 0) begin
				b_re = '0;
				b_im = '0;
			end
			send(cmd_t'($urandom_range(0, 7)), pick_val(), pick_val(), b_re, b_im);
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
